### hw/rtl/srpv_pkg.sv
// Shared types, constants and the CORDIC angle table for the sensor ring polar vector block.
// No dependencies; imported by every module of the block.
package srpv_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int W_NEAR          = 15137;   // cos 22.5 deg, Q.14
    localparam int W_FAR           = 6270;    // cos 67.5 deg, Q.14
    localparam int HALF_TURN       = 11520;   // 180 deg in 1/64 deg
    localparam int QUARTER_TURN    = 5760;

    // Cell chain layout
    localparam int SQRT_BITS    = 32;               // root bits, one per cell
    localparam int DIV_INIT     = SQRT_BITS + 1;    // dividend setup cell
    localparam int DIV_BITS     = 15;               // quotient bits, one per cell
    localparam int NUM_CELLS    = DIV_INIT + 1 + DIV_BITS;
    localparam int NORM_STEPS   = 6;                // shifts 32,16,8,4,2,1
    localparam int CORDIC_STEPS = 23;
    localparam int NORM_TOP     = 41;               // normalized max below 2^41

    typedef struct packed {
        logic               zero;
        logic               xneg;
        logic               yneg;
        logic               xzero;
        logic               yzero;
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic [63:0]        sq;      // x*x, then x*x+y*y, shifted out by the root cells
        logic [63:0]        yy;
        logic [35:0]        srem;
        logic [31:0]        root;
        logic [47:0]        nx;
        logic [47:0]        ny;
        logic [14:0]        qx;
        logic [14:0]        qy;
        logic signed [47:0] ca;
        logic signed [47:0] cb;
        logic [41:0]        cm;
        logic signed [31:0] cz;
    } stage_t;

    // atan(2^-i) in 1/65536 deg
    function automatic logic signed [31:0] angle_tab(input int i);
        logic signed [31:0] v;
        case (i)
            0:  v = 32'sd2949120;
            1:  v = 32'sd1740967;
            2:  v = 32'sd919879;
            3:  v = 32'sd466945;
            4:  v = 32'sd234379;
            5:  v = 32'sd117266;
            6:  v = 32'sd58666;
            7:  v = 32'sd29335;
            8:  v = 32'sd14668;
            9:  v = 32'sd7334;
            10: v = 32'sd3667;
            11: v = 32'sd1833;
            12: v = 32'sd917;
            13: v = 32'sd458;
            14: v = 32'sd229;
            15: v = 32'sd115;
            16: v = 32'sd57;
            17: v = 32'sd29;
            18: v = 32'sd14;
            19: v = 32'sd7;
            20: v = 32'sd4;
            21: v = 32'sd2;
            22: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/srpv_mag_step.sv
// Magnitude path step of one cell: sum of squares, one root bit, divider setup or one quotient bit.
// Depends on srpv_pkg.
module srpv_mag_step import srpv_pkg::*; #(
    parameter int STAGE = 0
) (
    input  stage_t din,
    output stage_t dout
);

    generate
        if (STAGE == 0) begin : g_sum
            always_comb begin
                dout    = din;
                dout.sq = din.sq + din.yy;
            end
        end else if (STAGE <= SQRT_BITS) begin : g_root
            always_comb begin
                logic [35:0] rem_sh;
                logic [35:0] trial;
                rem_sh = {din.srem[33:0], din.sq[63:62]};
                trial  = {2'b00, din.root, 2'b01};
                dout    = din;
                dout.sq = {din.sq[61:0], 2'b00};
                if (rem_sh >= trial) begin
                    dout.srem = rem_sh - trial;
                    dout.root = {din.root[30:0], 1'b1};
                end else begin
                    dout.srem = rem_sh;
                    dout.root = {din.root[30:0], 1'b0};
                end
            end
        end else if (STAGE == DIV_INIT) begin : g_div_init
            // dividend = 2*|c|*16384 + r, rounds half away from zero
            always_comb begin
                dout    = din;
                dout.nx = {1'b0, din.ax, 15'b0} + {16'b0, din.root};
                dout.ny = {1'b0, din.ay, 15'b0} + {16'b0, din.root};
                dout.qx = '0;
                dout.qy = '0;
            end
        end else if (STAGE < NUM_CELLS) begin : g_div
            localparam int K = NUM_CELLS - 1 - STAGE;
            always_comb begin
                logic [47:0] dk;
                dk   = 48'({din.root, 1'b0}) << K;
                dout = din;
                if (din.nx >= dk) begin
                    dout.nx = din.nx - dk;
                    dout.qx = {din.qx[13:0], 1'b1};
                end else begin
                    dout.qx = {din.qx[13:0], 1'b0};
                end
                if (din.ny >= dk) begin
                    dout.ny = din.ny - dk;
                    dout.qy = {din.qy[13:0], 1'b1};
                end else begin
                    dout.qy = {din.qy[13:0], 1'b0};
                end
            end
        end else begin : g_pass
            assign dout = din;
        end
    endgenerate

endmodule

### hw/rtl/srpv_ang_step.sv
// Bearing path step of one cell: one normalizing shift or one CORDIC vectoring rotation.
// Depends on srpv_pkg.
module srpv_ang_step import srpv_pkg::*; #(
    parameter int STAGE = 0
) (
    input  stage_t din,
    output stage_t dout
);

    generate
        if (STAGE < NORM_STEPS) begin : g_norm
            localparam int SH = 1 << (NORM_STEPS - 1 - STAGE);
            always_comb begin
                dout = din;
                if ((din.cm >> (NORM_TOP - SH)) == '0) begin
                    dout.ca = din.ca <<< SH;
                    dout.cb = din.cb <<< SH;
                    dout.cm = din.cm << SH;
                end
            end
        end else if (STAGE < NORM_STEPS + CORDIC_STEPS) begin : g_cordic
            localparam int I = STAGE - NORM_STEPS;
            always_comb begin
                logic signed [47:0] da;
                logic signed [47:0] db;
                da   = din.cb >>> I;
                db   = din.ca >>> I;
                dout = din;
                if (!din.cb[47]) begin
                    dout.ca = din.ca + da;
                    dout.cb = din.cb - db;
                    dout.cz = din.cz + angle_tab(I);
                end else begin
                    dout.ca = din.ca - da;
                    dout.cb = din.cb + db;
                    dout.cz = din.cz - angle_tab(I);
                end
            end
        end else begin : g_pass
            assign dout = din;
        end
    endgenerate

endmodule

### hw/rtl/srpv_cell.sv
// One cell of the chain: magnitude and bearing steps plus the stage register and its handshake.
// Depends on srpv_pkg, srpv_mag_step, srpv_ang_step.
module srpv_cell import srpv_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  stage_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output stage_t out_data
);

    stage_t mag_d;
    stage_t data_next;
    stage_t data_reg;
    logic   valid_reg;

    srpv_mag_step #(.STAGE(STAGE)) u_mag (.din(in_data), .dout(mag_d));
    srpv_ang_step #(.STAGE(STAGE)) u_ang (.din(mag_d), .dout(data_next));

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

### hw/rtl/sensor_ring_to_polar_vector.sv
// Top level of the sensor ring to polar vector block.
// Depends on srpv_pkg and srpv_cell (with srpv_mag_step and srpv_ang_step).

// Takes one frame of eight ring readings per transaction and returns one result transaction:
// unit vector (Q1.14), rounded magnitude, bearing atan2(x, y) in 1/64 degree measured from
// +y towards +x, and a zero-vector flag in m_tuser. The block is fully pipelined and accepts
// a frame every clock cycle while m_tready does not stall the output. The registered path is:
// two front stages form x, y and their squares, then a chain of 49 cells (sum of squares, 32
// integer square root bits, divider setup, 15 quotient bits for each unit component; the bearing
// normalize shifts and 23 CORDIC rotations run in the same cells), and a final output register
// that applies rounding, the 180 degree fold, the clamp and the axis and zero-vector cases.
// Each stage holds only while its successor is full and stalled, so bubbles are squeezed out
// and a frame is taken even while a result waits on m_tready.
module sensor_ring_to_polar_vector import srpv_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF   // low bits of each reading used, 8..16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // sensor_0 .. sensor_7, 16 bits each, sensor_0 lowest
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // unit_x[15:0], unit_y[31:16], magnitude[49:32],
                                    // bearing[64:50], zeros above
    output logic         m_tuser    // zero_vector
);

    localparam logic [15:0] SMASK = 16'((17'd1 << SAMPLE_BITS) - 17'd1);

    // ---------------- stage A: weighted differences ----------------
    logic [15:0]        s [8];
    logic signed [18:0] dnx, dfx, dny, dfy;
    logic signed [33:0] x_next, y_next;
    logic signed [33:0] x_reg, y_reg;
    logic               a_valid_reg;
    logic               a_load;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            s[i] = s_tdata[16*i +: 16] & SMASK;
        end
        dnx = $signed({3'b0, s[1]}) + $signed({3'b0, s[2]})
            - $signed({3'b0, s[5]}) - $signed({3'b0, s[6]});
        dfx = $signed({3'b0, s[0]}) + $signed({3'b0, s[3]})
            - $signed({3'b0, s[4]}) - $signed({3'b0, s[7]});
        dny = $signed({3'b0, s[0]}) + $signed({3'b0, s[7]})
            - $signed({3'b0, s[3]}) - $signed({3'b0, s[4]});
        dfy = $signed({3'b0, s[1]}) + $signed({3'b0, s[6]})
            - $signed({3'b0, s[2]}) - $signed({3'b0, s[5]});
        x_next = 34'(dnx) * 34'(W_NEAR) + 34'(dfx) * 34'(W_FAR);
        y_next = 34'(dny) * 34'(W_NEAR) + 34'(dfy) * 34'(W_FAR);
    end

    // ---------------- stage B: magnitudes, squares, CORDIC setup ----------------
    stage_t b_next;
    stage_t b_reg;
    logic   b_valid_reg;
    logic   b_load;

    always_comb begin
        logic [31:0] ax, ay;
        ax = 32'(x_reg[33] ? -x_reg : x_reg);
        ay = 32'(y_reg[33] ? -y_reg : y_reg);
        b_next       = '0;
        b_next.xneg  = x_reg[33];
        b_next.yneg  = y_reg[33];
        b_next.xzero = (x_reg == '0);
        b_next.yzero = (y_reg == '0);
        b_next.zero  = (x_reg == '0) && (y_reg == '0);
        b_next.ax    = ax;
        b_next.ay    = ay;
        b_next.sq    = {32'b0, ax} * {32'b0, ax};
        b_next.yy    = {32'b0, ay} * {32'b0, ay};
        // lower half plane is turned by 180 deg first
        b_next.ca    = y_reg[33] ? -48'(y_reg) : 48'(y_reg);
        b_next.cb    = y_reg[33] ? -48'(x_reg) : 48'(x_reg);
        b_next.cm    = 42'((ax > ay) ? ax : ay);
    end

    // ---------------- cell chain ----------------
    stage_t link_d [NUM_CELLS+1];
    logic   link_v [NUM_CELLS+1];
    logic   link_r [NUM_CELLS+1];
    logic   out_load;

    assign link_d[0] = b_reg;
    assign link_v[0] = b_valid_reg;
    assign link_r[NUM_CELLS] = out_load;

    generate
        for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
            srpv_cell #(.STAGE(g)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .in_valid (link_v[g]),
                .in_ready (link_r[g]),
                .in_data  (link_d[g]),
                .out_valid(link_v[g+1]),
                .out_ready(link_r[g+1]),
                .out_data (link_d[g+1])
            );
        end
    endgenerate

    assign b_load   = !b_valid_reg || link_r[0];
    assign a_load   = !a_valid_reg || b_load;
    assign s_tready = a_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_load) a_valid_reg <= s_tvalid;
            if (b_load) b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load && s_tvalid) begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
        if (b_load && a_valid_reg) begin
            b_reg <= b_next;
        end
    end

    // ---------------- output stage: finishing and result register ----------------
    stage_t             fin;
    logic signed [31:0] zr;
    logic signed [15:0] ang;
    logic signed [15:0] ux, uy;
    logic [17:0]        mag;
    logic [71:0]        m_tdata_next;
    logic [71:0]        m_tdata_reg;
    logic               m_tuser_reg;
    logic               m_tvalid_reg;

    assign fin = link_d[NUM_CELLS];

    always_comb begin
        zr  = (fin.cz + 32'sd512) >>> 10;
        ang = 16'(zr);
        if (fin.yneg) begin
            ang = ang + (fin.xneg ? -16'(HALF_TURN) : 16'(HALF_TURN));
        end
        if (ang > 16'(HALF_TURN)) begin
            ang = 16'(HALF_TURN);
        end else if (ang < -16'(HALF_TURN)) begin
            ang = -16'(HALF_TURN);
        end
        ux  = fin.xneg ? -16'({1'b0, fin.qx}) : 16'({1'b0, fin.qx});
        uy  = fin.yneg ? -16'({1'b0, fin.qy}) : 16'({1'b0, fin.qy});
        mag = 18'((33'(fin.root) + 33'd8192) >> 14);
        // axes take the exact angle; the zero vector clears everything
        if (fin.zero) begin
            ang = '0;
            ux  = '0;
            uy  = '0;
            mag = '0;
        end else if (fin.xzero) begin
            ang = fin.yneg ? 16'(HALF_TURN) : 16'sd0;
        end else if (fin.yzero) begin
            ang = fin.xneg ? -16'(QUARTER_TURN) : 16'(QUARTER_TURN);
        end
        m_tdata_next = {7'b0, ang[14:0], mag, uy, ux};
    end

    assign out_load = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= link_v[NUM_CELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && link_v[NUM_CELLS]) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= fin.zero;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- assertions ----------------
    a_zero_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[64:0] == '0)
        else $error("zero vector result carries nonzero fields");

    a_bearing_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[64:50]) <= 15'sd11520)
                  && ($signed(m_tdata[64:50]) >= -15'sd11520))
        else $error("bearing out of range");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384)
                  && ($signed(m_tdata[15:0]) >= -16'sd16384)
                  && ($signed(m_tdata[31:16]) <= 16'sd16384)
                  && ($signed(m_tdata[31:16]) >= -16'sd16384))
        else $error("unit component out of range");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        !a_valid_reg |-> s_tready)
        else $error("input stalled with empty front stage");

endmodule
